>>> rtl/uaf_pkg.sv
`default_nettype none

package uaf_pkg;

  // Ring geometry: RING_SIZE slots, one slot always stays empty
  localparam int RING_SIZE = 32;
  localparam int PTR_W     = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t PTR_LAST = ptr_t'(RING_SIZE - 1);
  localparam ptr_t FILL_MAX = ptr_t'(RING_SIZE - 1);

  // Operation codes carried in the input item
  localparam logic [2:0] OP_LINE_RX  = 3'd0;
  localparam logic [2:0] OP_HOST_RD  = 3'd1;
  localparam logic [2:0] OP_HOST_WR  = 3'd2;
  localparam logic [2:0] OP_TX_READY = 3'd3;
  localparam logic [2:0] OP_RX_CLEAR = 3'd4;

  // Sticky error bit positions
  localparam int ERR_FRM = 3;
  localparam int ERR_OVR = 2;
  localparam int ERR_PAR = 1;
  localparam int ERR_OVF = 0;

  // One input item, unpacked
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] line_byte;
    logic       line_frame_error;
    logic       line_overrun;
    logic       line_parity_error;
    logic [7:0] host_byte;
  } item_t;

  // Receive side status for the current item
  typedef struct packed {
    logic       rd_ok;
    logic       no_data;
    logic [3:0] errs;
    logic [7:0] avail;
  } rx_stat_t;

  // Transmit side status for the current item
  typedef struct packed {
    logic send;
    logic rejected;
    logic irq_en;
  } tx_stat_t;

  // Advance a ring pointer with wrap
  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/uaf_rx_ring.sv
`default_nettype none

module uaf_rx_ring (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire uaf_pkg::item_t    item,
  output uaf_pkg::rx_stat_t      stat,
  output logic [7:0]             rd_byte
);

  logic [7:0]    mem [uaf_pkg::RING_SIZE];
  uaf_pkg::ptr_t head_r, head_nxt;
  uaf_pkg::ptr_t tail_r, tail_nxt;
  uaf_pkg::ptr_t fill_r, fill_nxt;
  logic [3:0]    sticky_r, sticky_nxt;
  logic [7:0]    rd_byte_r;
  uaf_pkg::ptr_t nx_head;
  uaf_pkg::ptr_t nx_tail;
  logic          full;
  logic          empty;
  logic          is_rx;
  logic          is_rd;

  assign nx_head = uaf_pkg::ring_next(head_r);
  assign nx_tail = uaf_pkg::ring_next(tail_r);
  assign full    = (nx_head == tail_r);
  assign empty   = (head_r == tail_r);
  assign is_rx   = (item.op == uaf_pkg::OP_LINE_RX);
  assign is_rd   = (item.op == uaf_pkg::OP_HOST_RD);

  // Next pointer, count and error state
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    sticky_nxt = sticky_r;
    if (acc) begin
      case (item.op)
        uaf_pkg::OP_LINE_RX: begin
          if (!full) begin
            head_nxt = nx_head;
          end
          if (fill_r != uaf_pkg::FILL_MAX) begin
            fill_nxt = fill_r + uaf_pkg::ptr_t'(1);
          end
          // Drop the line flags when the byte itself is dropped
          sticky_nxt = sticky_r | (full ? 4'b0001 :
                       {item.line_frame_error, item.line_overrun,
                        item.line_parity_error, 1'b0});
        end
        uaf_pkg::OP_HOST_RD: begin
          if (!empty) begin
            tail_nxt   = nx_tail;
            sticky_nxt = '0;
            if (fill_r != '0) begin
              fill_nxt = fill_r - uaf_pkg::ptr_t'(1);
            end
          end
        end
        uaf_pkg::OP_RX_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          fill_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Status reported with this item
  always_comb begin
    stat.rd_ok   = is_rd && !empty;
    stat.no_data = is_rd && empty;
    stat.errs    = (is_rd && !empty) ? sticky_r : 4'b0000;
    stat.avail   = 8'(fill_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      sticky_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  // Byte store: write on a kept line byte, read on a host read
  always_ff @(posedge clk) begin
    if (acc && is_rx && !full) begin
      mem[nx_head] <= item.line_byte;
    end
    if (acc && is_rd) begin
      rd_byte_r <= mem[nx_tail];
    end
  end

  assign rd_byte = rd_byte_r;

endmodule

`default_nettype wire

>>> rtl/uaf_tx_ring.sv
`default_nettype none

module uaf_tx_ring (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire uaf_pkg::item_t    item,
  output uaf_pkg::tx_stat_t      stat,
  output logic [7:0]             tx_byte
);

  logic [7:0]    mem [uaf_pkg::RING_SIZE];
  uaf_pkg::ptr_t head_r, head_nxt;
  uaf_pkg::ptr_t tail_r, tail_nxt;
  logic          irq_r, irq_nxt;
  logic [7:0]    tx_byte_r;
  uaf_pkg::ptr_t nx_head;
  uaf_pkg::ptr_t nx_tail;
  logic          full;
  logic          empty;
  logic          is_wr;
  logic          is_rdy;

  assign nx_head = uaf_pkg::ring_next(head_r);
  assign nx_tail = uaf_pkg::ring_next(tail_r);
  assign full    = (nx_head == tail_r);
  assign empty   = (head_r == tail_r);
  assign is_wr   = (item.op == uaf_pkg::OP_HOST_WR);
  assign is_rdy  = (item.op == uaf_pkg::OP_TX_READY);

  // Next pointers and interrupt enable
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    irq_nxt  = irq_r;
    if (acc) begin
      case (item.op)
        uaf_pkg::OP_HOST_WR: begin
          if (!full) begin
            head_nxt = nx_head;
            irq_nxt  = 1'b1;
          end
        end
        uaf_pkg::OP_TX_READY: begin
          if (!empty) begin
            tail_nxt = nx_tail;
          end else begin
            irq_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status reported with this item
  always_comb begin
    stat.send     = is_rdy && !empty;
    stat.rejected = is_wr && full;
    stat.irq_en   = irq_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      irq_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      irq_r  <= irq_nxt;
    end
  end

  // Byte store: write on an accepted host write, read on transmitter ready
  always_ff @(posedge clk) begin
    if (acc && is_wr && !full) begin
      mem[nx_head] <= item.host_byte;
    end
    if (acc && is_rdy) begin
      tx_byte_r <= mem[nx_tail];
    end
  end

  assign tx_byte = tx_byte_r;

endmodule

`default_nettype wire

>>> rtl/uart_buffered_rx_tx_fifo_unit.sv
// Channel  | Dir | Ports                        | Contents
// ---------+-----+------------------------------+------------------------------------
// input    | in  | in_tvalid/in_tready/in_tdata | one event or host access, op in tuser
// result   | out | out_tvalid/out_tready/out_tdata | one status word per input item
//
// One item is accepted per cycle; its result is valid the cycle after.
// Both rings do their pointer update and store access at the accept edge,
// so back-to-back items see each other's updates with no bubble.
// The result register stalls the input only when it is full and not taken.
// Synchronous active-low reset empties both rings and clears sticky errors.
`default_nettype none

module uart_buffered_rx_tx_fifo_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] line_byte, [8] line_frame_error, [9] line_overrun,
  // [10] line_parity_error, [18:11] host_byte, [23:19] zero
  input  wire logic [23:0] in_tdata,
  // [2:0] op
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] read_data, [8] no_data, [9] err_frame, [10] err_overrun,
  // [11] err_parity, [12] err_buffer_overflow, [20:13] rx_available,
  // [21] line_send, [29:22] line_send_byte, [30] write_rejected,
  // [31] ready_irq_enable
  output logic [31:0]      out_tdata
);

  uaf_pkg::item_t    item;
  uaf_pkg::rx_stat_t rx_stat;
  uaf_pkg::tx_stat_t tx_stat;
  uaf_pkg::rx_stat_t rx_res_r;
  uaf_pkg::tx_stat_t tx_res_r;
  logic [7:0]        rx_byte;
  logic [7:0]        tx_byte;
  logic              out_valid_r, out_valid_nxt;
  logic              acc;

  // Unpack the input item
  assign item.op                = in_tuser;
  assign item.line_byte         = in_tdata[7:0];
  assign item.line_frame_error  = in_tdata[8];
  assign item.line_overrun      = in_tdata[9];
  assign item.line_parity_error = in_tdata[10];
  assign item.host_byte         = in_tdata[18:11];

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  uaf_rx_ring u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (item),
    .stat    (rx_stat),
    .rd_byte (rx_byte)
  );

  uaf_tx_ring u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (item),
    .stat    (tx_stat),
    .tx_byte (tx_byte)
  );

  // Result valid: load on accept, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      out_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result status until the next accept
  always_ff @(posedge clk) begin
    if (acc) begin
      rx_res_r <= rx_stat;
      tx_res_r <= tx_stat;
    end
  end

  // Pack the result item; store bytes show only on a successful pop
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {tx_res_r.irq_en,
                       tx_res_r.rejected,
                       tx_res_r.send ? tx_byte : 8'h00,
                       tx_res_r.send,
                       rx_res_r.avail,
                       rx_res_r.errs[uaf_pkg::ERR_OVF],
                       rx_res_r.errs[uaf_pkg::ERR_PAR],
                       rx_res_r.errs[uaf_pkg::ERR_OVR],
                       rx_res_r.errs[uaf_pkg::ERR_FRM],
                       rx_res_r.no_data,
                       rx_res_r.rd_ok ? rx_byte : 8'h00};

`ifndef SYNTH
  // Never load a new item over a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && out_valid_r && !out_tready))
    else $error("item accepted over a stalled result");

  // A full transmit ring always has the ready interrupt enabled
  a_full_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tx_res_r.rejected) |-> tx_res_r.irq_en)
    else $error("write rejected with ready interrupt disabled");

  // An empty read returns no byte and no errors
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rx_res_r.no_data) |-> (!rx_res_r.rd_ok && rx_res_r.errs == 4'b0000))
    else $error("empty read returned data or errors");

  // A pop and a send never come from the same item
  a_one_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rx_res_r.rd_ok && tx_res_r.send))
    else $error("receive pop and transmit send on one item");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;

  // Spare op codes: the block must leave its state alone on these
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_TAIL    = 100;
  localparam int HOLD_CYCLES  = 200;

  // Result word, highest field first so it overlays out_tdata directly
  typedef struct packed {
    logic       ready_irq_enable;
    logic       write_rejected;
    logic [7:0] line_send_byte;
    logic       line_send;
    logic [7:0] rx_available;
    logic       err_buffer_overflow;
    logic       err_parity;
    logic       err_overrun;
    logic       err_frame;
    logic       no_data;
    logic [7:0] read_data;
  } status_t;

  // One row of the directed table
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] line_byte;
    logic [2:0] line_flags;   // frame, overrun, parity
    logic [7:0] host_byte;
    logic       fixed;        // expected status typed in below
    status_t    status;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  uart_buffered_rx_tx_fifo_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow copy of both rings
  logic [7:0]    rx_ring [uaf_pkg::RING_SIZE];
  logic [7:0]    tx_ring [uaf_pkg::RING_SIZE];
  uaf_pkg::ptr_t rx_head, rx_tail, rx_fill;
  uaf_pkg::ptr_t tx_head, tx_tail;
  logic [3:0]    sticky;
  logic          tx_irq;

  status_t    pending_status [$];
  int         n_mismatch;
  int         n_items;
  bit         idle_en;
  bit         stall_en;
  bit         long_hold;

  function automatic uaf_pkg::ptr_t wrap_inc(input uaf_pkg::ptr_t p);
    return (p == uaf_pkg::ptr_t'(uaf_pkg::RING_SIZE - 1)) ? '0 : p + uaf_pkg::ptr_t'(1);
  endfunction

  // Apply one item to the shadow rings and return the status it produces
  function automatic status_t next_status(input logic [2:0] op, input logic [7:0] lb,
                                          input logic [2:0] flags, input logic [7:0] hb);
    status_t       s;
    uaf_pkg::ptr_t nx;
    logic [3:0]    e;
    s = '0;
    e = '0;
    e[uaf_pkg::ERR_FRM] = flags[2];
    e[uaf_pkg::ERR_OVR] = flags[1];
    e[uaf_pkg::ERR_PAR] = flags[0];
    case (op)
      uaf_pkg::OP_LINE_RX: begin
        nx = wrap_inc(rx_head);
        if (nx == rx_tail) begin
          // ring full: drop the byte and its line flags
          e = '0;
          e[uaf_pkg::ERR_OVF] = 1'b1;
        end else begin
          rx_head = nx;
          rx_ring[nx] = lb;
        end
        if (rx_fill != uaf_pkg::FILL_MAX) rx_fill = rx_fill + uaf_pkg::ptr_t'(1);
        sticky = sticky | e;
      end
      uaf_pkg::OP_HOST_RD: begin
        if (rx_head == rx_tail) begin
          s.no_data = 1'b1;
        end else begin
          nx = wrap_inc(rx_tail);
          rx_tail = nx;
          s.read_data = rx_ring[nx];
          if (rx_fill != '0) rx_fill = rx_fill - uaf_pkg::ptr_t'(1);
          s.err_frame           = sticky[uaf_pkg::ERR_FRM];
          s.err_overrun         = sticky[uaf_pkg::ERR_OVR];
          s.err_parity          = sticky[uaf_pkg::ERR_PAR];
          s.err_buffer_overflow = sticky[uaf_pkg::ERR_OVF];
          sticky = '0;
        end
      end
      uaf_pkg::OP_HOST_WR: begin
        nx = wrap_inc(tx_head);
        if (nx == tx_tail) begin
          s.write_rejected = 1'b1;
        end else begin
          tx_ring[nx] = hb;
          tx_head = nx;
          tx_irq = 1'b1;
        end
      end
      uaf_pkg::OP_TX_READY: begin
        if (tx_head != tx_tail) begin
          nx = wrap_inc(tx_tail);
          tx_tail = nx;
          s.line_send = 1'b1;
          s.line_send_byte = tx_ring[nx];
        end else begin
          tx_irq = 1'b0;
        end
      end
      uaf_pkg::OP_RX_CLEAR: begin
        rx_head = '0;
        rx_tail = '0;
        rx_fill = '0;
      end
      default: ;
    endcase
    s.rx_available = 8'(rx_fill);
    s.ready_irq_enable = tx_irq;
    return s;
  endfunction

  // Build a status word for the directed table; errs is frame, overrun, parity, overflow
  function automatic status_t st(input logic [7:0] rd, input logic nd, input logic [3:0] errs,
                                 input logic [7:0] avail, input logic send,
                                 input logic [7:0] sbyte, input logic rej, input logic irq);
    status_t s;
    s.read_data           = rd;
    s.no_data             = nd;
    s.err_frame           = errs[3];
    s.err_overrun         = errs[2];
    s.err_parity          = errs[1];
    s.err_buffer_overflow = errs[0];
    s.rx_available        = avail;
    s.line_send           = send;
    s.line_send_byte      = sbyte;
    s.write_rejected      = rej;
    s.ready_irq_enable    = irq;
    return s;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_mismatch++;
  endtask

  // Offer one item, wait for its handshake, then log what it should produce
  task automatic send_item(input logic [2:0] op, input logic [7:0] lb, input logic [2:0] flags,
                           input logic [7:0] hb, input logic fixed, input status_t status);
    int      gap;
    status_t s;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, hb, flags[0], flags[1], flags[2], lb};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    s = next_status(op, lb, flags, hb);
    pending_status.push_back(fixed ? status : s);
    if (op <= uaf_pkg::OP_RX_CLEAR) n_items++;
  endtask

  task automatic send_random(input logic [2:0] op);
    logic [2:0] flags;
    flags[2] = ($urandom_range(0, 7) == 0);
    flags[1] = ($urandom_range(0, 7) == 0);
    flags[0] = ($urandom_range(0, 7) == 0);
    send_item(op, 8'($urandom), flags, 8'($urandom), 1'b0, '0);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata);
      if (pending_status.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = pending_status.pop_front();
        if (got.read_data !== want.read_data)
          flag_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        if (got.no_data !== want.no_data)
          flag_mismatch($sformatf("no_data %b, want %b", got.no_data, want.no_data));
        if (got.err_frame !== want.err_frame)
          flag_mismatch($sformatf("err_frame %b, want %b", got.err_frame, want.err_frame));
        if (got.err_overrun !== want.err_overrun)
          flag_mismatch($sformatf("err_overrun %b, want %b",
                                  got.err_overrun, want.err_overrun));
        if (got.err_parity !== want.err_parity)
          flag_mismatch($sformatf("err_parity %b, want %b", got.err_parity, want.err_parity));
        if (got.err_buffer_overflow !== want.err_buffer_overflow)
          flag_mismatch($sformatf("err_buffer_overflow %b, want %b",
                                  got.err_buffer_overflow, want.err_buffer_overflow));
        if (got.rx_available !== want.rx_available)
          flag_mismatch($sformatf("rx_available %0d, want %0d",
                                  got.rx_available, want.rx_available));
        if (got.line_send !== want.line_send)
          flag_mismatch($sformatf("line_send %b, want %b", got.line_send, want.line_send));
        if (got.line_send_byte !== want.line_send_byte)
          flag_mismatch($sformatf("line_send_byte %h, want %h",
                                  got.line_send_byte, want.line_send_byte));
        if (got.write_rejected !== want.write_rejected)
          flag_mismatch($sformatf("write_rejected %b, want %b",
                                  got.write_rejected, want.write_rejected));
        if (got.ready_irq_enable !== want.ready_irq_enable)
          flag_mismatch($sformatf("ready_irq_enable %b, want %b",
                                  got.ready_irq_enable, want.ready_irq_enable));
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off to back up the input
  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    row_t dir [23];
    int   i;
    int   pick;
    bit   hold_done;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    n_mismatch = 0;
    n_items    = 0;
    idle_en    = 1'b1;
    stall_en   = 1'b1;
    long_hold  = 1'b0;
    hold_done  = 1'b0;
    rx_head = '0; rx_tail = '0; rx_fill = '0;
    tx_head = '0; tx_tail = '0;
    sticky = '0;
    tx_irq = 1'b0;
    for (i = 0; i < uaf_pkg::RING_SIZE; i++) begin
      rx_ring[i] = '0;
      tx_ring[i] = '0;
    end

    // Directed rows: empty rings, extreme bytes, every op, clear keeps errors
    dir[0]  = {uaf_pkg::OP_HOST_RD,  8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b1, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[1]  = {uaf_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[2]  = {OP_SPARE_7,           8'hff, 3'b111, 8'hff, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[3]  = {uaf_pkg::OP_LINE_RX,  8'hff, 3'b111, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd1, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[4]  = {uaf_pkg::OP_LINE_RX,  8'h00, 3'b000, 8'hff, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd2, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[5]  = {uaf_pkg::OP_HOST_RD,  8'h00, 3'b000, 8'h00, 1'b1,
               st(8'hff, 1'b0, 4'b1110, 8'd1, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[6]  = {uaf_pkg::OP_HOST_RD,  8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[7]  = {uaf_pkg::OP_HOST_RD,  8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b1, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[8]  = {uaf_pkg::OP_HOST_WR,  8'h00, 3'b000, 8'hff, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir[9]  = {uaf_pkg::OP_HOST_WR,  8'hff, 3'b111, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir[10] = {uaf_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b1, 8'hff, 1'b0, 1'b1)};
    dir[11] = {uaf_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b1, 8'h00, 1'b0, 1'b1)};
    dir[12] = {uaf_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[13] = {OP_SPARE_5,           8'h12, 3'b101, 8'h34, 1'b0, 32'h0};
    dir[14] = {OP_SPARE_6,           8'h56, 3'b010, 8'h78, 1'b0, 32'h0};
    dir[15] = {uaf_pkg::OP_LINE_RX,  8'ha5, 3'b001, 8'h00, 1'b0, 32'h0};
    dir[16] = {uaf_pkg::OP_LINE_RX,  8'h5a, 3'b100, 8'h00, 1'b0, 32'h0};
    dir[17] = {uaf_pkg::OP_RX_CLEAR, 8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b0, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[18] = {uaf_pkg::OP_HOST_RD,  8'h00, 3'b000, 8'h00, 1'b1,
               st(8'h00, 1'b1, 4'b0000, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir[19] = {uaf_pkg::OP_LINE_RX,  8'h3c, 3'b010, 8'h00, 1'b0, 32'h0};
    dir[20] = {uaf_pkg::OP_HOST_RD,  8'h00, 3'b000, 8'h00, 1'b0, 32'h0};
    dir[21] = {uaf_pkg::OP_HOST_WR,  8'hff, 3'b111, 8'h5a, 1'b0, 32'h0};
    dir[22] = {uaf_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00, 1'b0, 32'h0};

    // Hold reset, then release it on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir[k])
      send_item(dir[k].op, dir[k].line_byte, dir[k].line_flags, dir[k].host_byte,
                dir[k].fixed, dir[k].status);

    // Random part: fill and drain bursts push both rings past full and empty
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: repeat ($urandom_range(28, 36)) send_random(uaf_pkg::OP_LINE_RX);
        1: repeat ($urandom_range(5, 36)) send_random(uaf_pkg::OP_HOST_RD);
        2: repeat ($urandom_range(28, 36)) send_random(uaf_pkg::OP_HOST_WR);
        3: repeat ($urandom_range(5, 36)) send_random(uaf_pkg::OP_TX_READY);
        4: send_random(uaf_pkg::OP_RX_CLEAR);
        default: begin
          repeat ($urandom_range(5, 20)) begin
            if ($urandom_range(0, 19) == 0)
              send_random(3'($urandom_range(5, 7)));
            else
              send_random(3'($urandom_range(0, 4)));
          end
        end
      endcase
      // Back up the input once with a long stall on the result side
      if (!hold_done && n_items > 150) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      // Run the tail at full rate
      if (n_items > RANDOM_ITEMS - CALM_TAIL) begin
        idle_en  = 1'b0;
        stall_en = 1'b0;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipe settle
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (n_mismatch == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/uaf_pkg.sv
rtl/uaf_rx_ring.sv
rtl/uaf_tx_ring.sv
rtl/uart_buffered_rx_tx_fifo_unit.sv
bench/testbench.sv
